// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SCM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define SCM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/scm_pkg.sv -----
// types, codes and coefficient formulas for the subtitle color matrix remap
package scm_pkg;

    localparam int COEF_FRAC_BITS = 16;
    localparam int COLOR_BITS     = 8;

    localparam int COEF_W  = COEF_FRAC_BITS + 3;
    localparam int X_W     = COLOR_BITS + 1;
    localparam int PROD_W  = COEF_W + X_W;
    localparam int ACC_W   = COEF_FRAC_BITS + 14;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam int INV_SETS = 6;
    localparam int FWD_SETS = 8;

    localparam longint COEF_ONE  = longint'(1) << COEF_FRAC_BITS;
    localparam longint LUMA_DEN  = 10000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SUB_MATRIX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_CS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_RANGE = 2'd2;

    // subtitle matrix codes
    localparam logic [3:0] SUB_DEFAULT  = 4'd0;
    localparam logic [3:0] SUB_UNKNOWN  = 4'd1;
    localparam logic [3:0] SUB_NONE     = 4'd2;
    localparam logic [3:0] SUB_601_TV   = 4'd3;
    localparam logic [3:0] SUB_601_PC   = 4'd4;
    localparam logic [3:0] SUB_709_TV   = 4'd5;
    localparam logic [3:0] SUB_709_PC   = 4'd6;
    localparam logic [3:0] SUB_240M_TV  = 4'd7;
    localparam logic [3:0] SUB_240M_PC  = 4'd8;

    // frame colorspace codes
    localparam logic [3:0] CS_RGB       = 4'd0;
    localparam logic [3:0] CS_BT709     = 4'd1;
    localparam logic [3:0] CS_UNSPEC    = 4'd2;
    localparam logic [3:0] CS_RESERVED  = 4'd3;
    localparam logic [3:0] CS_FCC       = 4'd4;
    localparam logic [3:0] CS_BT470BG   = 4'd5;
    localparam logic [3:0] CS_SMPTE170M = 4'd6;
    localparam logic [3:0] CS_SMPTE240M = 4'd7;

    // frame range codes
    localparam logic [1:0] RANGE_UNSPEC = 2'd0;
    localparam logic [1:0] RANGE_TV     = 2'd1;
    localparam logic [1:0] RANGE_PC     = 2'd2;
    localparam logic [1:0] RANGE_EXT    = 2'd3;

    localparam logic [COLOR_BITS-1:0] Y_OFF_TV = 8'd16;
    localparam logic [COLOR_BITS-1:0] C_OFF    = 8'd128;

    typedef enum logic [1:0] {
        KIND_601 = 2'd0,
        KIND_709 = 2'd1,
        KIND_240 = 2'd2,
        KIND_RGB = 2'd3
    } kind_e;

    typedef enum logic {
        LEV_TV = 1'b0,
        LEV_PC = 1'b1
    } lev_e;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t [2:0] coef_row_t;
    typedef coef_row_t [2:0] coef_mat_t;
    typedef logic signed [X_W-1:0] xval_t;
    typedef xval_t [2:0] xvec_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [2:0][COLOR_BITS-1:0] color_vec_t;

    localparam acc_t ACC_ZERO = '0;
    localparam acc_t ACC_HALF = acc_t'(longint'(1) << (COEF_FRAC_BITS - 1));

    typedef struct packed {
        logic [COLOR_BITS-1:0] red_in;
        logic [COLOR_BITS-1:0] green_in;
        logic [COLOR_BITS-1:0] blue_in;
        logic [COLOR_BITS-1:0] transparency_in;
    } in_beat_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red_out;
        logic [COLOR_BITS-1:0] green_out;
        logic [COLOR_BITS-1:0] blue_out;
        logic [COLOR_BITS-1:0] opacity_out;
        logic                  remapped;
    } out_beat_t;

    typedef struct packed {
        logic [3:0] sub_matrix;
        logic [3:0] frame_cs;
        logic [1:0] frame_range;
    } cfg_t;

    typedef struct packed {
        logic                  bypass;
        coef_mat_t             inv;
        coef_mat_t             fwd;
        logic [COLOR_BITS-1:0] ioff_y;
        color_vec_t            foff;
    } coef_sel_t;

    typedef struct packed {
        logic                  bypass;
        color_vec_t            rgb;
        logic [COLOR_BITS-1:0] opacity;
    } stage_info_t;

    // exact rational value of a coefficient, rounded later at elaboration
    typedef struct packed {
        longint num;
        longint den;
    } ratio_t;

    localparam longint LUMA_TAB [3][3] = '{
        '{2990, 5870, 1140},
        '{2126, 7152, 722},
        '{2122, 7013, 865}
    };

    // level gains, tv first then pc
    localparam longint LEV_YN [2] = '{255, 1};
    localparam longint LEV_YD [2] = '{219, 1};
    localparam longint LEV_CN [2] = '{255, 255};
    localparam longint LEV_CD [2] = '{224, 254};

    // rgb to ycbcr, set is {kind, level}
    function automatic ratio_t inv_ratio(input int set, input int row, input int col);
        int k;
        int lv;
        longint a;
        longint b;
        longint c;
        ratio_t r;
        k  = set >> 1;
        lv = set & 1;
        a  = LUMA_TAB[k][0];
        b  = LUMA_TAB[k][1];
        c  = LUMA_TAB[k][2];
        case (row)
            0: r = '{LEV_YD[lv] * LUMA_TAB[k][col], LEV_YN[lv] * LUMA_DEN};
            1: begin
                case (col)
                    0:       r = '{-LEV_CD[lv] * a, LEV_CN[lv] * 2 * (LUMA_DEN - c)};
                    1:       r = '{-LEV_CD[lv] * b, LEV_CN[lv] * 2 * (LUMA_DEN - c)};
                    default: r = '{LEV_CD[lv], LEV_CN[lv] * 2};
                endcase
            end
            default: begin
                case (col)
                    0:       r = '{LEV_CD[lv], LEV_CN[lv] * 2};
                    1:       r = '{-LEV_CD[lv] * b, LEV_CN[lv] * 2 * (LUMA_DEN - a)};
                    default: r = '{-LEV_CD[lv] * c, LEV_CN[lv] * 2 * (LUMA_DEN - a)};
                endcase
            end
        endcase
        return r;
    endfunction

    // ycbcr to rgb, set is {kind, level}; the rgb kind is the identity
    function automatic ratio_t fwd_ratio(input int set, input int row, input int col);
        int k;
        int lv;
        longint a;
        longint b;
        longint c;
        longint cn;
        longint cd;
        ratio_t r;
        k  = set >> 1;
        lv = set & 1;
        r  = '{0, 1};
        if (k == int'(KIND_RGB)) begin
            if (row == col) r = '{1, 1};
        end else begin
            a  = LUMA_TAB[k][0];
            b  = LUMA_TAB[k][1];
            c  = LUMA_TAB[k][2];
            cn = LEV_CN[lv];
            cd = LEV_CD[lv];
            if (col == 0) begin
                r = '{LEV_YN[lv], LEV_YD[lv]};
            end else begin
                case (row)
                    0: begin
                        if (col == 2) r = '{cn * 2 * (LUMA_DEN - a), cd * LUMA_DEN};
                    end
                    1: begin
                        if (col == 1) r = '{-cn * 2 * (LUMA_DEN - c) * c, cd * LUMA_DEN * b};
                        else          r = '{-cn * 2 * (LUMA_DEN - a) * a, cd * LUMA_DEN * b};
                    end
                    default: begin
                        if (col == 1) r = '{cn * 2 * (LUMA_DEN - c), cd * LUMA_DEN};
                    end
                endcase
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/scm_lane.sv -----
// one lane: a three-term affine row with round to nearest and clip
module scm_lane import scm_pkg::*; (
    input  coef_row_t              coef,
    input  xvec_t                  x,
    input  acc_t                   bias,
    output logic [COLOR_BITS-1:0]  y
);

    logic signed [PROD_W-1:0] prod [3];
    acc_t                     acc;
    acc_t                     rnd;
    logic [ACC_W-COEF_FRAC_BITS-1:0] whole;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            prod[j] = $signed(coef[j]) * $signed(x[j]);
        end
        acc   = bias + acc_t'(prod[0]) + acc_t'(prod[1]) + acc_t'(prod[2]);
        rnd   = acc + ACC_HALF;
        whole = rnd[ACC_W-1:COEF_FRAC_BITS];
        if (acc[ACC_W-1]) begin
            y = '0;
        end else if (|whole[ACC_W-COEF_FRAC_BITS-1:COLOR_BITS]) begin
            y = '1;
        end else begin
            y = whole[COLOR_BITS-1:0];
        end
    end

endmodule

// ----- rtl/scm_coef.sv -----
// coefficient tables and decode of the subtitle matrix, frame colorspace and frame range registers
module scm_coef import scm_pkg::*; (
    input  cfg_t      cfg,
    output coef_sel_t sel
);

    wire coef_mat_t inv_tab [INV_SETS];
    wire coef_mat_t fwd_tab [FWD_SETS];

    for (genvar gs = 0; gs < INV_SETS; gs++) begin : g_inv_set
        for (genvar gr = 0; gr < 3; gr++) begin : g_row
            for (genvar gc = 0; gc < 3; gc++) begin : g_col
                localparam ratio_t R = inv_ratio(gs, gr, gc);
                localparam longint MAG =
                    (((R.num < 0) ? -R.num : R.num) * COEF_ONE + R.den / 2) / R.den;
                assign inv_tab[gs][gr][gc] = COEF_W'((R.num < 0) ? -MAG : MAG);
            end
        end
    end

    for (genvar gs = 0; gs < FWD_SETS; gs++) begin : g_fwd_set
        for (genvar gr = 0; gr < 3; gr++) begin : g_row
            for (genvar gc = 0; gc < 3; gc++) begin : g_col
                localparam ratio_t R = fwd_ratio(gs, gr, gc);
                localparam longint MAG =
                    (((R.num < 0) ? -R.num : R.num) * COEF_ONE + R.den / 2) / R.den;
                assign fwd_tab[gs][gr][gc] = COEF_W'((R.num < 0) ? -MAG : MAG);
            end
        end
    end

    kind_e      skind;
    kind_e      fkind;
    lev_e       slev;
    lev_e       flev;
    logic       s_ok;
    logic       f_ok;
    logic       f_can_match;
    logic [2:0] inv_set;
    logic [2:0] fwd_set;

    always_comb begin
        s_ok        = 1'b1;
        f_ok        = 1'b1;
        f_can_match = 1'b1;
        skind       = KIND_601;
        slev        = LEV_TV;
        fkind       = KIND_601;
        flev        = LEV_TV;

        case (cfg.sub_matrix)
            SUB_DEFAULT, SUB_601_TV: begin
                skind = KIND_601;
                slev  = LEV_TV;
            end
            SUB_601_PC: begin
                skind = KIND_601;
                slev  = LEV_PC;
            end
            SUB_709_TV: begin
                skind = KIND_709;
                slev  = LEV_TV;
            end
            SUB_709_PC: begin
                skind = KIND_709;
                slev  = LEV_PC;
            end
            SUB_240M_TV: begin
                skind = KIND_240;
                slev  = LEV_TV;
            end
            SUB_240M_PC: begin
                skind = KIND_240;
                slev  = LEV_PC;
            end
            default: s_ok = 1'b0;
        endcase

        // code 1 converts as bt601 on purpose
        case (cfg.frame_cs)
            CS_RGB:                             fkind = KIND_RGB;
            CS_BT709, CS_BT470BG, CS_SMPTE170M: fkind = KIND_601;
            CS_SMPTE240M:                       fkind = KIND_240;
            CS_UNSPEC, CS_RESERVED, CS_FCC:     f_ok = 1'b0;
            default: begin
                fkind       = KIND_601;
                f_can_match = 1'b0;
            end
        endcase

        case (cfg.frame_range)
            RANGE_TV: flev = LEV_TV;
            RANGE_PC: flev = LEV_PC;
            RANGE_EXT: begin
                flev        = LEV_TV;
                f_can_match = 1'b0;
            end
            default: f_ok = 1'b0;
        endcase

        inv_set = {skind, slev};
        fwd_set = {fkind, flev};

        sel.bypass = !s_ok || !f_ok ||
                     (f_can_match && (skind == fkind) && (slev == flev));
        sel.inv    = inv_tab[s_ok ? inv_set : 3'd0];
        sel.fwd    = fwd_tab[fwd_set];
        sel.ioff_y = (slev == LEV_PC) ? '0 : Y_OFF_TV;
        if (fkind == KIND_RGB) begin
            sel.foff = '0;
        end else begin
            sel.foff[0] = (flev == LEV_PC) ? '0 : Y_OFF_TV;
            sel.foff[1] = C_OFF;
            sel.foff[2] = C_OFF;
        end
    end

endmodule

// ----- rtl/scm_merge.sv -----
// merge stage: picks lane results or the bypassed color and holds the output beat
module scm_merge import scm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  stage_info_t info,
    input  color_vec_t  lane_rgb,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data
);

    logic      m_valid_reg;
    out_beat_t m_data_reg;
    out_beat_t m_data_next;

    assign in_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_data_next.red_out     = info.bypass ? info.rgb[0] : lane_rgb[0];
        m_data_next.green_out   = info.bypass ? info.rgb[1] : lane_rgb[1];
        m_data_next.blue_out    = info.bypass ? info.rgb[2] : lane_rgb[2];
        m_data_next.opacity_out = info.opacity;
        m_data_next.remapped    = !info.bypass;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/subtitle_color_matrix_remap_top.sv -----
// top level of the subtitle color matrix remap
//
// s_ channel takes one subtitle color per beat (red, green, blue, transparency);
// m_ channel returns the remapped color, opacity and a remapped flag per beat.
// both channels are valid/ready; a beat moves when valid and ready are high.
// cfg_we/cfg_index/cfg_wdata write the subtitle matrix, frame colorspace and
// frame range registers; write them only while no beat is in flight.
// from s_ accept to m_valid: three lanes do the rgb to ycbcr rows into a
// register, a second set of three lanes does the ycbcr to rgb rows, and the
// merge stage picks lane or bypass result into the output register.
// throughput is one beat per cycle while m_ready does not stall the output.
// reset clears the pipeline valids and loads the register reset values,
// which select bypass.
// a stalled m_ready holds the output beat; s_ready stays high while an
// earlier stage is empty, so one beat waits behind a stalled output and
// s_ready drops once it is there.
module subtitle_color_matrix_remap_top import scm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    coef_sel_t   sel;

    logic        v1_reg;
    color_vec_t  yuv_reg;
    stage_info_t info_reg;
    logic        mid_ready;

    xvec_t       x1;
    xvec_t       x2;
    acc_t        bias1 [3];
    logic [COLOR_BITS-1:0] y1 [3];
    logic [COLOR_BITS-1:0] y2 [3];
    color_vec_t  lane_rgb;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_SUB_MATRIX:  cfg_next.sub_matrix  = cfg_wdata;
                REG_FRAME_CS:    cfg_next.frame_cs    = cfg_wdata;
                REG_FRAME_RANGE: cfg_next.frame_range = cfg_wdata[1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sub_matrix  <= SUB_DEFAULT;
            cfg_reg.frame_cs    <= CS_UNSPEC;
            cfg_reg.frame_range <= RANGE_UNSPEC;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    scm_coef u_coef (
        .cfg (cfg_reg),
        .sel (sel)
    );

    // stage one inputs: rgb straight in, offsets pre-scaled; stage two inputs: yuv_reg less the frame offsets
    always_comb begin
        x1[0]    = xval_t'({1'b0, s_data.red_in});
        x1[1]    = xval_t'({1'b0, s_data.green_in});
        x1[2]    = xval_t'({1'b0, s_data.blue_in});
        bias1[0] = acc_t'(sel.ioff_y) << COEF_FRAC_BITS;
        bias1[1] = acc_t'(C_OFF) << COEF_FRAC_BITS;
        bias1[2] = acc_t'(C_OFF) << COEF_FRAC_BITS;
        for (int j = 0; j < 3; j++) begin
            x2[j] = $signed({1'b0, yuv_reg[j]}) - $signed({1'b0, sel.foff[j]});
        end
        for (int j = 0; j < 3; j++) begin
            lane_rgb[j] = y2[j];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        scm_lane u_lane_inv (
            .coef (sel.inv[g]),
            .x    (x1),
            .bias (bias1[g]),
            .y    (y1[g])
        );
        scm_lane u_lane_fwd (
            .coef (sel.fwd[g]),
            .x    (x2),
            .bias (ACC_ZERO),
            .y    (y2[g])
        );
    end

    assign s_ready = !v1_reg || mid_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_ready) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            yuv_reg[0]       <= y1[0];
            yuv_reg[1]       <= y1[1];
            yuv_reg[2]       <= y1[2];
            info_reg.bypass  <= sel.bypass;
            info_reg.rgb[0]  <= s_data.red_in;
            info_reg.rgb[1]  <= s_data.green_in;
            info_reg.rgb[2]  <= s_data.blue_in;
            info_reg.opacity <= ~s_data.transparency_in;
        end
    end

    scm_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (v1_reg),
        .in_ready (mid_ready),
        .info     (info_reg),
        .lane_rgb (lane_rgb),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- rtl/scm_checker.sv -----
// port-level checker for the subtitle color matrix remap, bound to the top level
`include "assert_macros.svh"

module scm_checker import scm_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    // a stalled result beat is not dropped
    `SCM_ASSERT(a_m_valid_hold, m_valid && !m_ready |=> m_valid, "result beat dropped while stalled")

    // a stalled result beat keeps its payload
    `SCM_ASSERT(a_m_data_hold, m_valid && !m_ready |=> $stable(m_data), "result payload changed while stalled")

    `SCM_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")

    // an empty output stage means the whole pipe can take a beat
    `SCM_ASSERT(a_ready_when_empty, !m_valid |-> s_ready, "input stalled with empty output")

    // an accepted beat reaches m_valid through the stage one and output registers when the receiver is ready
    `SCM_ASSERT(a_latency, s_valid && s_ready ##1 m_ready |=> m_valid, "result beat late")

endmodule

bind subtitle_color_matrix_remap_top scm_checker u_scm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
